// ----- hw/rtl/actt_pkg.sv -----
// shared types and constants for the adaptive connect timeout table
// no dependencies; imported by the top level
`default_nettype none

package actt_pkg;

  // field widths fixed by the request format
  localparam int unsigned CmdW     = 2;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned MsW      = 20;
  localparam int unsigned TmoW     = 22;
  localparam int unsigned FailW    = 16;
  localparam int unsigned EntryW   = 24;

  localparam logic [MsW-1:0] CeilingReset = MsW'(10000);

  // x / 3 as (x * Div3Mul) >> Div3Shift, exact for x < 2**Div3Shift
  localparam int unsigned Div3Shift = 23;
  localparam logic [Div3Shift-1:0] Div3Mul = Div3Shift'((2 ** Div3Shift + 1) / 3);

  typedef enum logic [CmdW-1:0] {
    CMD_SUGGEST = 2'd0,
    CMD_SUCCESS = 2'd1,
    CMD_FAIL    = 2'd2,
    CMD_PUBLISH = 2'd3
  } cmd_e;

endpackage

`default_nettype wire

// ----- hw/rtl/actt_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// no dependencies; read during write at one address returns the old data
`default_nettype none

module actt_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/adaptive_connect_timeout_table.sv -----
// accepted request -> valid_q -> strobe_q raises the result strobe; one request per cycle
// throughput: a new request every cycle, busy is never raised
// the entry read uses the ram's registered port; a write-back it has not yet seen is forwarded
// reset clears presence bits, failure counter and strobe; ceiling returns to 10000 ms
// entry durations stay undefined until written and are never read before that
// depends on actt_pkg and actt_ram
`default_nettype none

module adaptive_connect_timeout_table
  import actt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic              cfg_we_i,
  input  wire logic [MsW-1:0]    cfg_wdata_i,
  input  wire logic [CmdW-1:0]   cmd_i,
  input  wire logic [IdxW-1:0]   entry_index_i,
  input  wire logic [MsW-1:0]    min_timeout_i,
  input  wire logic [MsW-1:0]    duration_i,
  output logic                   strobe_o,
  output logic      [TmoW-1:0]   timeout_o,
  output logic      [FailW-1:0]  failure_count_o
);

  localparam int unsigned AW = $clog2(ENTRIES);
  localparam int unsigned NumIdx = 2 ** IdxW;
  localparam int unsigned SumW = MsW + 2;

  logic              accept;
  logic [AW-1:0]     rd_idx;

  logic              valid_q;
  cmd_e              cmd_q;
  logic [AW-1:0]     idx_q;
  logic [MsW-1:0]    mn_q;
  logic [MsW-1:0]    dur_q;

  logic [MsW-1:0]    ceiling_q;
  logic [ENTRIES-1:0] present_q, present_d;
  logic [FailW-1:0]  failures_q, failures_d;

  logic              fwd_q;
  logic [AW-1:0]     fwd_idx_q;
  logic [EntryW-1:0] fwd_data_q;

  logic              strobe_q;
  logic [TmoW-1:0]   timeout_q, timeout_d;

  logic [EntryW-1:0] ram_rdata;
  logic              ram_we;
  logic [EntryW-1:0] ram_wdata;

  logic [EntryW-1:0]         s;
  logic                      s_present;
  logic [EntryW+1:0]         s3;
  logic [EntryW:0]           r_abs;
  logic [MsW-1:0]            r_clip;
  logic [TmoW-1:0]           mn3;
  logic [MsW-1:0]            s_base;
  logic [SumW-1:0]           sum;
  logic [SumW+Div3Shift-1:0] prod;
  logic [MsW:0]              quot;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // index wraps modulo the table depth
  always_comb begin
    rd_idx = '0;
    for (int i = 0; i < NumIdx; i++) begin
      if (entry_index_i == IdxW'(i)) begin
        rd_idx = AW'(i % ENTRIES);
      end
    end
  end

  actt_ram #(
    .Width (EntryW),
    .Depth (ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (rd_idx),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    s         = (fwd_q && fwd_idx_q == idx_q) ? fwd_data_q : ram_rdata;
    s_present = present_q[idx_q];

    // suggest on a known entry: |3*s| clamped to [min, ceiling], min tested first
    s3    = {{2{s[EntryW-1]}}, s} + {s[EntryW-1], s, 1'b0};
    r_abs = s3[EntryW+1] ? (EntryW+1)'(-s3) : s3[EntryW:0];
    if (r_abs < (EntryW+1)'(mn_q)) begin
      r_clip = mn_q;
    end else if (r_abs > (EntryW+1)'(ceiling_q)) begin
      r_clip = ceiling_q;
    end else begin
      r_clip = r_abs[MsW-1:0];
    end
    mn3 = {2'b00, mn_q} + {1'b0, mn_q, 1'b0};

    // success filter: (base + 2*duration) / 3
    s_base = (!s_present || s[EntryW-1]) ? dur_q : s[MsW-1:0];
    sum    = {2'b00, s_base} + {1'b0, dur_q, 1'b0};
    prod   = {{Div3Shift{1'b0}}, sum} * {{SumW{1'b0}}, Div3Mul};
    quot   = prod[Div3Shift+MsW:Div3Shift];

    ram_we     = 1'b0;
    ram_wdata  = s;
    timeout_d  = '0;
    failures_d = failures_q;
    present_d  = present_q;

    if (valid_q) begin
      unique case (cmd_q)
        CMD_SUGGEST: begin
          ram_we = 1'b1;
          if (s_present) begin
            ram_wdata = s[EntryW-1] ? -EntryW'(r_clip) : EntryW'(r_clip);
            timeout_d = TmoW'(r_clip);
          end else begin
            ram_wdata = -EntryW'(mn3);
            timeout_d = mn3;
          end
        end
        CMD_SUCCESS: begin
          ram_we    = 1'b1;
          ram_wdata = EntryW'(quot);
          if (failures_q != '0) begin
            failures_d = failures_q - 1'b1;
          end
        end
        CMD_FAIL: begin
          if (failures_q != '1) begin
            failures_d = failures_q + 1'b1;
          end
        end
        CMD_PUBLISH: begin
          if (failures_q != '0) begin
            failures_d = failures_q - 1'b1;
          end
        end
        default: begin
        end
      endcase
      if (ram_we) begin
        present_d[idx_q] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      ceiling_q  <= CeilingReset;
      present_q  <= '0;
      failures_q <= '0;
      fwd_q      <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      valid_q    <= accept;
      if (cfg_we_i) begin
        ceiling_q <= cfg_wdata_i;
      end
      present_q  <= present_d;
      failures_q <= failures_d;
      fwd_q      <= ram_we;
      strobe_q   <= valid_q;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(cmd_i);
      idx_q <= rd_idx;
      mn_q  <= min_timeout_i;
      dur_q <= duration_i;
    end
    fwd_idx_q  <= idx_q;
    fwd_data_q <= ram_wdata;
    timeout_q  <= timeout_d;
  end

  assign strobe_o        = strobe_q;
  assign timeout_o       = timeout_q;
  assign failure_count_o = failures_q;

  a_strobe_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |=> strobe_o)
    else $error("result strobe missing after request in flight");

  a_no_spurious_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |=> !strobe_o)
    else $error("result strobe without request");

  a_fail_idle_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !valid_q |=> $stable(failures_q))
    else $error("failure counter changed without request");

  a_fail_inc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cmd_q == CMD_FAIL && failures_q != '1)
      |=> failures_q == $past(failures_q) + 1'b1)
    else $error("failure counter did not increment");

  a_zero_timeout: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && cmd_q != CMD_SUGGEST) |=> timeout_o == '0)
    else $error("nonzero timeout on non-suggest result");

endmodule

`default_nettype wire

// ----- tb/sv/timeout_table_checker.sv -----
// predicts and checks the replies of the adaptive connect timeout table
// watches request, config and reply ports; uses types from actt_pkg
module timeout_table_checker
  import actt_pkg::*;
#(
  parameter int unsigned ENTRIES = 16
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire logic             busy_i,
  input  wire logic             cfg_we_i,
  input  wire logic [MsW-1:0]   cfg_wdata_i,
  input  wire cmd_e             cmd_i,
  input  wire logic [IdxW-1:0]  entry_index_i,
  input  wire logic [MsW-1:0]   min_timeout_i,
  input  wire logic [MsW-1:0]   duration_i,
  input  wire logic             strobe_i,
  input  wire logic [TmoW-1:0]  timeout_i,
  input  wire logic [FailW-1:0] failure_count_i,
  output int unsigned           pending_o,
  output int unsigned           mismatches_o
);

  typedef struct packed {
    logic [TmoW-1:0]  timeout;
    logic [FailW-1:0] failure_count;
  } table_reply_t;

  logic                     present [ENTRIES];
  logic signed [EntryW-1:0] stored  [ENTRIES];
  logic [FailW-1:0]         fails;
  logic [MsW-1:0]           ceiling;
  table_reply_t             replies_due [$];
  table_reply_t             next_reply;
  table_reply_t             due;

  task automatic flag_mismatch(input string what, input longint got, input longint want);
    $display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
    mismatches_o = mismatches_o + 1;
  endtask

  task automatic apply_command(input cmd_e c, input logic [IdxW-1:0] idx,
                               input logic [MsW-1:0] mn, input logic [MsW-1:0] dur,
                               output table_reply_t rep);
    int unsigned slot;
    longint      s;
    longint      r;
    longint      mn_l;
    longint      dur_l;
    longint      ceil_l;
    slot   = idx % ENTRIES;
    mn_l   = longint'(mn);
    dur_l  = longint'(dur);
    ceil_l = longint'(ceiling);
    rep.timeout = '0;
    case (c)
      CMD_SUGGEST: begin
        if (!present[slot]) begin
          present[slot] = 1'b1;
          stored[slot]  = EntryW'(-3 * mn_l);
          rep.timeout   = TmoW'(3 * mn_l);
        end else begin
          s = longint'(stored[slot]);
          r = 3 * s;
          if (r < 0) r = -r;
          // minimum is tested first, so the minimum wins when both apply
          if (r < mn_l) begin
            r = mn_l;
          end else if (r > ceil_l) begin
            r = ceil_l;
          end
          stored[slot] = EntryW'((s < 0) ? -r : r);
          rep.timeout  = TmoW'(r);
        end
      end
      CMD_SUCCESS: begin
        // unconfirmed or absent entries restart from the measured duration
        if (!present[slot] || stored[slot] < 0) begin
          present[slot] = 1'b1;
          stored[slot]  = EntryW'(dur_l);
        end
        s = longint'(stored[slot]);
        stored[slot] = EntryW'((s + 2 * dur_l) / 3);
        if (fails != '0) fails = fails - 1'b1;
      end
      CMD_FAIL: begin
        if (fails != {FailW{1'b1}}) fails = fails + 1'b1;
      end
      default: begin
        if (fails != '0) fails = fails - 1'b1;
      end
    endcase
    rep.failure_count = fails;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        present[i] = 1'b0;
        stored[i]  = '0;
      end
      fails   = '0;
      ceiling = CeilingReset;
      replies_due.delete();
      mismatches_o = 0;
      pending_o   <= 0;
    end else begin
      if (strobe_i) begin
        if (replies_due.size() == 0) begin
          flag_mismatch("unexpected reply, timeout", timeout_i, 0);
        end else begin
          due = replies_due.pop_front();
          if (timeout_i !== due.timeout)
            flag_mismatch("timeout", timeout_i, due.timeout);
          if (failure_count_i !== due.failure_count)
            flag_mismatch("failure_count", failure_count_i, due.failure_count);
        end
      end
      if (cfg_we_i) ceiling = cfg_wdata_i;
      if (start_i && !busy_i) begin
        apply_command(cmd_i, entry_index_i, min_timeout_i, duration_i, next_reply);
        replies_due.push_back(next_reply);
      end
      pending_o <= replies_due.size();
    end
  end

endmodule

// ----- tb/sv/tb_adaptive_connect_timeout_table.sv -----
// top of the adaptive connect timeout table testbench: clock, reset, requests
// depends on actt_pkg, adaptive_connect_timeout_table and timeout_table_checker
module tb_adaptive_connect_timeout_table;
  import actt_pkg::*;

  localparam int unsigned ENTRIES    = 16;
  localparam int unsigned StallLimit = 2000;
  localparam int unsigned DrainWait  = 8;

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  logic             cfg_we      = 1'b0;
  logic [MsW-1:0]   cfg_wdata   = '0;
  cmd_e             cmd         = CMD_SUGGEST;
  logic [IdxW-1:0]  entry_index = '0;
  logic [MsW-1:0]   min_timeout = '0;
  logic [MsW-1:0]   duration    = '0;
  logic             strobe;
  logic [TmoW-1:0]  timeout;
  logic [FailW-1:0] failure_count;
  int unsigned      replies_pending;
  int unsigned      mismatches;
  int unsigned      quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  adaptive_connect_timeout_table #(
    .ENTRIES(ENTRIES)
  ) i_dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .cmd_i          (cmd),
    .entry_index_i  (entry_index),
    .min_timeout_i  (min_timeout),
    .duration_i     (duration),
    .strobe_o       (strobe),
    .timeout_o      (timeout),
    .failure_count_o(failure_count)
  );

  timeout_table_checker #(
    .ENTRIES(ENTRIES)
  ) i_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .busy_i         (busy),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .cmd_i          (cmd),
    .entry_index_i  (entry_index),
    .min_timeout_i  (min_timeout),
    .duration_i     (duration),
    .strobe_i       (strobe),
    .timeout_i      (timeout),
    .failure_count_i(failure_count),
    .pending_o      (replies_pending),
    .mismatches_o   (mismatches)
  );

  // ends the run when neither a request nor a reply moves for too long
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic send_request(input cmd_e c, input int unsigned idx,
                              input logic [MsW-1:0] mn, input logic [MsW-1:0] dur);
    start       <= 1'b1;
    cmd         <= c;
    entry_index <= IdxW'(idx);
    min_timeout <= mn;
    duration    <= dur;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic pause_requests(input int unsigned n);
    if (n > 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // pending count is registered, so give the last request time to show up
  task automatic wait_drained();
    start <= 1'b0;
    repeat (2) @(posedge clk);
    while (replies_pending != 0) @(posedge clk);
  endtask

  task automatic write_ceiling(input logic [MsW-1:0] value);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [MsW-1:0] pick_ms();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return {MsW{1'b1}};
      2:       return MsW'($urandom_range(0, 63));
      3:       return MsW'($urandom_range(0, 20000));
      default: return MsW'($urandom());
    endcase
  endfunction

  function automatic cmd_e pick_chain_cmd();
    int unsigned p;
    p = $urandom_range(0, 19);
    if (p < 10) return CMD_SUGGEST;
    if (p < 16) return CMD_SUCCESS;
    if (p < 18) return CMD_FAIL;
    return CMD_PUBLISH;
  endfunction

  // bursts mostly work one entry so suggest and success chains build up state
  task automatic run_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned burst;
    int unsigned idx;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(1, 12);
      idx   = $urandom_range(0, ENTRIES - 1);
      for (int k = 0; k < burst; k++) begin
        if ($urandom_range(0, 3) != 0) begin
          send_request(pick_chain_cmd(), idx, pick_ms(), pick_ms());
        end else begin
          send_request(cmd_e'($urandom_range(0, 3)), $urandom_range(0, 15),
                       MsW'($urandom()), MsW'($urandom()));
        end
        sent++;
      end
      if ($urandom_range(0, 39) == 0) begin
        wait_drained();
      end else if ($urandom_range(0, 2) != 0) begin
        pause_requests($urandom_range(1, 8));
      end
    end
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part, reset ceiling of 10000 ms
    send_request(CMD_SUGGEST, 0, '0, '0);            // zero suggestion counts as confirmed
    send_request(CMD_SUGGEST, 0, MsW'(5), '0);
    send_request(CMD_SUGGEST, 1, {MsW{1'b1}}, '0);    // largest first suggestion
    send_request(CMD_SUGGEST, 1, MsW'(100), '0);      // cut to the ceiling
    send_request(CMD_SUGGEST, 1, MsW'(20000), '0);    // minimum above the ceiling
    send_request(CMD_SUGGEST, 1, {MsW{1'b1}}, '0);    // raised to the minimum
    send_request(CMD_SUCCESS, 1, '0, {MsW{1'b1}});    // unconfirmed entry reloads
    send_request(CMD_FAIL, 3, {MsW{1'b1}}, {MsW{1'b1}});
    send_request(CMD_FAIL, 15, '0, '0);
    send_request(CMD_FAIL, 7, '0, '0);
    send_request(CMD_SUCCESS, 2, '0, '0);             // absent entry
    send_request(CMD_SUCCESS, 1, '0, '0);
    send_request(CMD_SUGGEST, 1, '0, '0);
    send_request(CMD_PUBLISH, 0, '0, '0);
    send_request(CMD_PUBLISH, 0, '0, '0);
    send_request(CMD_PUBLISH, 0, '0, '0);             // counter already zero
    send_request(CMD_SUCCESS, 2, '0, '0);
    send_request(CMD_SUGGEST, 15, MsW'(7), '0);
    send_request(CMD_SUCCESS, 15, '0, MsW'(1000));    // negative entry reloads
    send_request(CMD_SUCCESS, 15, '0, MsW'(1));       // confirmed entry filters
    send_request(CMD_SUGGEST, 15, MsW'(3), '0);
    send_request(CMD_SUGGEST, 2, {MsW{1'b1}}, '0);
    send_request(CMD_SUCCESS, 14, {MsW{1'b1}}, {MsW{1'b1}});
    send_request(CMD_SUGGEST, 14, '0, '0);

    write_ceiling('0);
    run_traffic(290);
    write_ceiling({MsW{1'b1}});
    run_traffic(290);
    write_ceiling(MsW'($urandom_range(1, 2000)));
    run_traffic(290);
    write_ceiling(MsW'($urandom()));
    run_traffic(290);
    write_ceiling(CeilingReset);
    run_traffic(200);

    // a run of failures back to back, then count down and up again
    for (int n = 0; n < 16; n++) begin
      send_request(CMD_FAIL, $urandom_range(0, 15), pick_ms(), pick_ms());
    end
    send_request(CMD_PUBLISH, 0, '0, '0);
    send_request(CMD_FAIL, 0, '0, '0);
    send_request(CMD_FAIL, 0, '0, '0);
    run_traffic(60);

    wait_drained();
    repeat (DrainWait) @(posedge clk);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/actt_pkg.sv
hw/rtl/actt_ram.sv
hw/rtl/adaptive_connect_timeout_table.sv
tb/sv/timeout_table_checker.sv
tb/sv/tb_adaptive_connect_timeout_table.sv
